[hdl/sliding_window_tile_map_defines.svh]
// Assertion helpers for the tile map.
`ifndef SLIDING_WINDOW_TILE_MAP_DEFINES_SVH
`define SLIDING_WINDOW_TILE_MAP_DEFINES_SVH
`define SWTM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define SWTM_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

[hdl/swtm_pkg.sv]
package swtm_pkg;
    localparam logic [1:0] OP_GET  = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_TAKE = 2'd2;
    localparam logic [1:0] OP_RECENTER = 2'd3;
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OUT = 2'd1;
    localparam logic [1:0] ST_OCC = 2'd2;
    typedef struct packed {
        logic [1:0]  op;
        logic signed [16:0] lx;
        logic signed [16:0] ly;
        logic        inwin;
        logic [15:0] handle;
        logic signed [15:0] px;
        logic signed [15:0] py;
    } t_cmd;
endpackage

[hdl/swtm_front.sv]
module swtm_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [15:0]        i_handle_in,
    input  logic signed [15:0] i_center_x,
    input  logic signed [15:0] i_center_y,
    input  logic               i_radius_ok,
    input  logic [3:0]         i_radius,
    output logic               o_valid,
    input  logic               i_stall,
    output swtm_pkg::t_cmd     o_cmd
);
    // two-entry queue; intake stalls while it holds a command, so only one entry is ever occupied
    swtm_pkg::t_cmd r_q [2];
    logic [1:0] r_cnt;
    logic r_rd, r_wr;
    swtm_pkg::t_cmd w_c;
    logic w_in, w_out;
    always_comb begin
        w_c.op = i_op;
        w_c.lx = 17'(i_pos_x) - 17'(i_center_x);
        w_c.ly = 17'(i_pos_y) - 17'(i_center_y);
        w_c.inwin = (w_c.lx >= -$signed({1'b0, i_radius})) && (w_c.lx <= $signed({1'b0, i_radius}))
            && (w_c.ly >= -$signed({1'b0, i_radius})) && (w_c.ly <= $signed({1'b0, i_radius}))
            && i_radius_ok;
        w_c.handle = i_handle_in;
        w_c.px = i_pos_x;
        w_c.py = i_pos_y;
    end
    // a recenter in flight changes the center; hold intake until queue empties
    assign o_stall = r_cnt != 2'd0;
    assign w_in = i_valid && !o_stall;
    assign w_out = o_valid && !i_stall;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd = r_q[r_rd];
    always_ff @(posedge i_clk) begin
        if (w_in) r_q[r_wr] <= w_c;
        if (!i_rst_n) begin
            r_cnt <= '0; r_rd <= 1'b0; r_wr <= 1'b0;
        end else begin
            if (w_in) r_wr <= !r_wr;
            if (w_out) r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(w_in) - 2'(w_out);
        end
    end
endmodule

[hdl/swtm_back.sv]
`include "sliding_window_tile_map_defines.svh"
module swtm_back #(
    parameter int RADIUS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  swtm_pkg::t_cmd     i_cmd,
    output logic signed [15:0] o_center_x,
    output logic signed [15:0] o_center_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [15:0]        o_handle_out,
    output logic               o_evicted,
    output logic               o_last
);
    localparam int SIDE = 2 * RADIUS + 1;
    localparam int SLOTS = SIDE * SIDE;
    localparam int IW = $clog2(SLOTS);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLR   = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_MOVE  = 3'd3;
    localparam logic [2:0] S_EVRD  = 3'd4;
    localparam logic [2:0] S_EVCK  = 3'd5;
    localparam logic [2:0] S_EVEND = 3'd6;
    // two banks: the live window and the one a recenter fills
    logic [15:0] r_mem [2][SLOTS];
    logic [15:0] r_rd;
    logic r_bank;
    logic [2:0] r_st;
    logic signed [16:0] r_dx, r_dy;
    logic [IW-1:0] r_i;
    logic signed [4:0] r_x, r_y;
    logic signed [15:0] r_cx, r_cy;
    logic [1:0] r_op;
    logic r_inwin;
    logic [15:0] r_hin;
    logic [IW-1:0] r_aidx;
    logic r_mv, r_mvin;
    logic [IW-1:0] r_mvi;
    logic r_pv;
    logic [15:0] r_ph;
    logic r_ov;
    logic [1:0] r_ostat;
    logic [15:0] r_oh;
    logic r_oev, r_olast;
    logic w_ofree, w_take, w_same;
    logic [IW-1:0] w_idx;
    logic signed [17:0] w_ox, w_oy, w_mx, w_my;
    logic w_oin, w_moved, w_evict;
    logic [IW-1:0] w_oidx, w_ridx, w_widx;
    logic w_we, w_wbank, w_accwe;
    logic [15:0] w_wdata;
    logic w_emit;
    logic [1:0] w_ostat;
    logic [15:0] w_oh;
    logic w_oev, w_olast;
    assign w_ofree = !r_ov || !i_stall;
    assign o_stall = (r_st != S_IDLE) || !w_ofree;
    assign w_take = i_valid && !o_stall;
    assign w_same = (i_cmd.px == r_cx) && (i_cmd.py == r_cy);
    assign w_idx = IW'((i_cmd.lx + 17'(RADIUS)) + (i_cmd.ly + 17'(RADIUS)) * 17'(SIDE));
    // move: origin of destination (r_x,r_y); evict: destination of origin (r_x,r_y)
    always_comb begin
        w_ox = 18'(r_x) + 18'(r_dx);
        w_oy = 18'(r_y) + 18'(r_dy);
        w_oin = (w_ox >= -18'(RADIUS)) && (w_ox <= 18'(RADIUS))
            && (w_oy >= -18'(RADIUS)) && (w_oy <= 18'(RADIUS));
        w_oidx = IW'((w_ox + 18'(RADIUS)) + (w_oy + 18'(RADIUS)) * 18'(SIDE));
        w_mx = 18'(r_x) - 18'(r_dx);
        w_my = 18'(r_y) - 18'(r_dy);
        w_moved = (w_mx >= -18'(RADIUS)) && (w_mx <= 18'(RADIUS))
            && (w_my >= -18'(RADIUS)) && (w_my <= 18'(RADIUS));
        w_evict = (r_rd != 16'd0) && !w_moved;
    end
    assign w_accwe = (r_st == S_ACC) && w_ofree && r_inwin
        && ((r_op == swtm_pkg::OP_SET && r_rd == 16'd0) || r_op == swtm_pkg::OP_TAKE);
    always_comb begin
        w_we = 1'b0; w_wbank = r_bank; w_widx = r_i; w_wdata = '0;
        if (r_mv) begin
            w_we = 1'b1; w_wbank = !r_bank; w_widx = r_mvi;
            w_wdata = r_mvin ? r_rd : '0;
        end else if (w_accwe) begin
            w_we = 1'b1; w_widx = r_aidx;
            w_wdata = (r_op == swtm_pkg::OP_SET) ? r_hin : '0;
        end else if (r_st == S_CLR) begin
            w_we = 1'b1;
        end
    end
    always_comb begin
        unique case (r_st)
            S_IDLE: w_ridx = w_idx;
            S_ACC: w_ridx = r_aidx;
            S_MOVE: w_ridx = w_oidx;
            default: w_ridx = r_i;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wbank][w_widx] <= w_wdata;
        r_rd <= r_mem[r_bank][w_ridx];
    end
    always_comb begin
        w_emit = 1'b0; w_ostat = swtm_pkg::ST_OK; w_oh = '0; w_oev = 1'b0; w_olast = 1'b1;
        unique case (r_st)
            S_IDLE: w_emit = w_take && (i_cmd.op == swtm_pkg::OP_RECENTER) && w_same;
            S_ACC: begin
                w_emit = w_ofree;
                if (!r_inwin) w_ostat = swtm_pkg::ST_OUT;
                else if (r_op == swtm_pkg::OP_SET) begin
                    if (r_rd != 16'd0) w_ostat = swtm_pkg::ST_OCC;
                end else w_oh = r_rd;
            end
            // hold one evicted word back so the final one can carry last
            S_EVCK: begin
                w_emit = w_ofree && w_evict && r_pv;
                w_oh = r_ph; w_oev = 1'b1; w_olast = 1'b0;
            end
            S_EVEND: begin
                w_emit = w_ofree;
                if (r_pv) begin
                    w_oh = r_ph; w_oev = 1'b1;
                end
            end
            default: ;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (w_emit) r_ov <= 1'b1;
        else if (!i_stall) r_ov <= 1'b0;
        if (w_emit) begin
            r_ostat <= w_ostat; r_oh <= w_oh; r_oev <= w_oev; r_olast <= w_olast;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_i <= '0; r_bank <= 1'b0; r_mv <= 1'b0;
            r_pv <= 1'b0; r_cx <= '0; r_cy <= '0;
        end else begin
            r_mv <= (r_st == S_MOVE);
            unique case (r_st)
                S_CLR: begin
                    if (int'(r_i) == SLOTS - 1) r_st <= S_IDLE;
                    else r_i <= r_i + 1'b1;
                end
                S_IDLE: begin
                    if (w_take) begin
                        r_op <= i_cmd.op; r_inwin <= i_cmd.inwin;
                        r_hin <= i_cmd.handle; r_aidx <= w_idx;
                        if (i_cmd.op == swtm_pkg::OP_RECENTER) begin
                            r_dx <= 17'(i_cmd.px) - 17'(r_cx);
                            r_dy <= 17'(i_cmd.py) - 17'(r_cy);
                            if (!w_same) begin
                                r_cx <= i_cmd.px; r_cy <= i_cmd.py;
                                r_i <= '0; r_x <= -5'(RADIUS); r_y <= -5'(RADIUS);
                                r_pv <= 1'b0; r_st <= S_MOVE;
                            end
                        end else begin
                            r_st <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    if (w_ofree) r_st <= S_IDLE;
                end
                S_MOVE: begin
                    if (int'(r_i) == SLOTS - 1) begin
                        r_st <= S_EVRD; r_i <= '0;
                        r_x <= -5'(RADIUS); r_y <= -5'(RADIUS);
                    end else begin
                        r_i <= r_i + 1'b1;
                        if (r_x == 5'(RADIUS)) begin
                            r_x <= -5'(RADIUS); r_y <= r_y + 5'sd1;
                        end else r_x <= r_x + 5'sd1;
                    end
                    r_mvi <= r_i; r_mvin <= w_oin;
                end
                S_EVRD: r_st <= S_EVCK;
                S_EVCK: begin
                    if (!w_evict || !r_pv || w_ofree) begin
                        if (w_evict) begin
                            r_pv <= 1'b1; r_ph <= r_rd;
                        end
                        if (int'(r_i) == SLOTS - 1) begin
                            r_st <= S_EVEND;
                        end else begin
                            r_st <= S_EVRD; r_i <= r_i + 1'b1;
                            if (r_x == 5'(RADIUS)) begin
                                r_x <= -5'(RADIUS); r_y <= r_y + 5'sd1;
                            end else r_x <= r_x + 5'sd1;
                        end
                    end
                end
                S_EVEND: begin
                    if (w_ofree) begin
                        r_pv <= 1'b0; r_bank <= !r_bank; r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
    assign o_center_x = r_cx;
    assign o_center_y = r_cy;
    assign o_valid = r_ov;
    assign o_status = r_ostat;
    assign o_handle_out = r_oh;
    assign o_evicted = r_oev;
    assign o_last = r_olast;
    `SWTM_ASSERT(a_hold, i_clk, i_rst_n, r_ov && i_stall |=> r_ov && $stable(r_oh))
    `SWTM_ASSERT(a_ev_ok, i_clk, i_rst_n, r_ov && r_oev |-> r_ostat == swtm_pkg::ST_OK)
    `SWTM_ASSERT(a_busy, i_clk, i_rst_n, r_st != S_IDLE |-> o_stall)
    `SWTM_ASSERT(a_emit_free, i_clk, i_rst_n, w_emit |-> w_ofree)
endmodule

[hdl/sliding_window_tile_map.sv]
// Get, set and take: front queue, back-end table read, then the output register; the back end
// takes no new command until the word is registered. Recenter to the same center: one word,
// registered as the back end takes the command. Other recenters: a slot move, an eviction scan
// that reads and checks each slot in turn and a closing state; the last word comes from that
// state, and output stalls lengthen the scan. Synchronous active-low reset zeroes the center,
// then a clearing pass empties every slot of the live bank while the back end takes nothing.
module sliding_window_tile_map #(
    parameter int RADIUS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [15:0]        i_handle_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic [15:0]        o_handle_out,
    output logic               o_evicted,
    output logic               o_last
);
    swtm_pkg::t_cmd w_cmd;
    logic w_v, w_s;
    logic signed [15:0] w_cx, w_cy;
    swtm_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_op, .i_pos_x, .i_pos_y, .i_handle_in,
        .i_center_x(w_cx), .i_center_y(w_cy), .i_radius_ok(1'b1), .i_radius(4'(RADIUS)),
        .o_valid(w_v), .i_stall(w_s), .o_cmd(w_cmd)
    );
    swtm_back #(.RADIUS(RADIUS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_v), .o_stall(w_s), .i_cmd(w_cmd),
        .o_center_x(w_cx), .o_center_y(w_cy), .o_valid, .i_stall,
        .o_status, .o_handle_out, .o_evicted, .o_last
    );
endmodule
